// File: hdl/delta_sample_playback_channel_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta sample channel
// Clocked property checks, gated off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DELTA_SAMPLE_PLAYBACK_CHANNEL_CORE_ASSERT_SVH
`define DELTA_SAMPLE_PLAYBACK_CHANNEL_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset
`define DSPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every rising edge outside reset
`define DSPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/dspc_pkg.sv
// ----------------------------------------------------------------------------
// dspc_pkg
// Types, codes and constants shared by the delta sample channel.
// ----------------------------------------------------------------------------
package dspc_pkg;

  // Request operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_REG_WR = 2'd1;
  localparam logic [1:0] OP_ENABLE = 2'd2;

  // Channel register offsets
  localparam logic [1:0] REG_FLAGS  = 2'd0;
  localparam logic [1:0] REG_LEVEL  = 2'd1;
  localparam logic [1:0] REG_START  = 2'd2;
  localparam logic [1:0] REG_LENGTH = 2'd3;

  localparam logic [15:0] ADDR_WRAP  = 16'h8000;
  localparam logic [15:0] ADDR_RESET = 16'hC000;
  localparam logic [15:0] ADDR_LAST  = 16'hFFFF;
  localparam logic [6:0]  LEVEL_TOP  = 7'd126;
  localparam logic [3:0]  BITS_FULL  = 4'd8;
  localparam logic [11:0] LEN_RESET  = 12'd1;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] reg_index;
    logic [7:0] write_data;
    logic       enable;
    logic [7:0] mem_byte;
  } dspc_req_t;

  typedef struct packed {
    logic [6:0]  level;
    logic        fetched;
    logic [15:0] fetch_address;
    logic        bytes_left;
  } dspc_rsp_t;

  // Input register contents handed to the channel logic
  typedef struct packed {
    logic      valid;
    dspc_req_t req;
  } dspc_stage_t;

  // Timer reload value, counted down by tick requests, for each rate index
  function automatic logic [8:0] rate_period(input logic [3:0] idx);
    logic [8:0] p;
    unique case (idx)
      4'd0:    p = 9'd428;
      4'd1:    p = 9'd380;
      4'd2:    p = 9'd340;
      4'd3:    p = 9'd320;
      4'd4:    p = 9'd286;
      4'd5:    p = 9'd254;
      4'd6:    p = 9'd226;
      4'd7:    p = 9'd214;
      4'd8:    p = 9'd190;
      4'd9:    p = 9'd160;
      4'd10:   p = 9'd142;
      4'd11:   p = 9'd128;
      4'd12:   p = 9'd106;
      4'd13:   p = 9'd84;
      4'd14:   p = 9'd72;
      default: p = 9'd54;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/dspc_if.sv
// ----------------------------------------------------------------------------
// dspc request and result channels
// Valid/ready handshake carrying one request or one result.
// ----------------------------------------------------------------------------
interface dspc_req_if import dspc_pkg::*; ();
  logic      valid;
  logic      ready;
  dspc_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dspc_rsp_if import dspc_pkg::*; ();
  logic      valid;
  logic      ready;
  dspc_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/dspc_in_stage.sv
// ----------------------------------------------------------------------------
// dspc_in_stage
// Input register: captures one request and holds it until it moves on.
// ----------------------------------------------------------------------------
module dspc_in_stage import dspc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  dspc_req_t   in_req_i,
  output logic        in_ready_o,
  input  logic        advance_i,
  output dspc_stage_t stage_o
);

  logic      valid_q, valid_d;
  dspc_req_t req_q;

  // take a new request when empty or when the held one moves on
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.req   = req_q;

endmodule

// File: hdl/dspc_channel.sv
// ----------------------------------------------------------------------------
// dspc_channel
// Channel state: timer, sample reader, output shifter and level.
// ----------------------------------------------------------------------------
module dspc_channel import dspc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dspc_stage_t stage_i,
  input  logic        advance_i,
  output dspc_rsp_t   rsp_o
);

  logic [8:0]  timer_count_q, timer_count_d;
  logic [8:0]  timer_period_q, timer_period_d;
  logic        loop_on_q, loop_on_d;
  logic [6:0]  out_level_q, out_level_d;
  logic [15:0] start_address_q, start_address_d;
  logic [11:0] start_length_q, start_length_d;
  logic [15:0] cur_address_q, cur_address_d;
  logic [11:0] cur_length_q, cur_length_d;
  logic [7:0]  sample_byte_q, sample_byte_d;
  logic        sample_valid_q, sample_valid_d;
  logic [7:0]  shifter_q, shifter_d;
  logic [3:0]  bits_left_q, bits_left_d;
  logic        silent_q, silent_d;
  logic        fetched;
  logic        fire;
  dspc_req_t   req;

  assign req  = stage_i.req;
  assign fire = stage_i.valid && advance_i;

  always_comb begin
    timer_count_d   = timer_count_q;
    timer_period_d  = timer_period_q;
    loop_on_d       = loop_on_q;
    out_level_d     = out_level_q;
    start_address_d = start_address_q;
    start_length_d  = start_length_q;
    cur_address_d   = cur_address_q;
    cur_length_d    = cur_length_q;
    sample_byte_d   = sample_byte_q;
    sample_valid_d  = sample_valid_q;
    shifter_d       = shifter_q;
    bits_left_d     = bits_left_q;
    silent_d        = silent_q;
    fetched         = 1'b0;

    case (req.op)
      OP_TICK: begin
        if (timer_count_q != 9'd0) begin
          timer_count_d = timer_count_q - 9'd1;
        end else begin
          timer_count_d = timer_period_q;
          // reader: refill the empty buffer while bytes remain
          if (!sample_valid_q && cur_length_q != 12'd0) begin
            fetched        = 1'b1;
            sample_byte_d  = req.mem_byte;
            sample_valid_d = 1'b1;
            cur_address_d  = (cur_address_q == ADDR_LAST) ? ADDR_WRAP
                                                          : cur_address_q + 16'd1;
            cur_length_d   = cur_length_q - 12'd1;
            if (cur_length_d == 12'd0 && loop_on_q) begin
              cur_address_d = start_address_q;
              cur_length_d  = start_length_q;
            end
          end
          // output unit: step the level by one shifted bit
          if (!silent_q) begin
            if (!shifter_q[0]) begin
              if (out_level_q > 7'd1) begin
                out_level_d = out_level_q - 7'd2;
              end
            end else begin
              if (out_level_q < LEVEL_TOP) begin
                out_level_d = out_level_q + 7'd2;
              end
            end
            shifter_d = {1'b0, shifter_q[7:1]};
          end
          bits_left_d = bits_left_q - 4'd1;
          if (bits_left_d == 4'd0) begin
            bits_left_d = BITS_FULL;
            if (!sample_valid_d) begin
              silent_d = 1'b1;
            end else begin
              silent_d       = 1'b0;
              shifter_d      = sample_byte_d;
              sample_valid_d = 1'b0;
            end
          end
        end
      end
      OP_REG_WR: begin
        unique case (req.reg_index)
          REG_FLAGS: begin
            loop_on_d      = req.write_data[6];
            timer_period_d = rate_period(req.write_data[3:0]);
            timer_count_d  = timer_period_d;
          end
          REG_LEVEL: begin
            out_level_d = req.write_data[6:0];
          end
          REG_START: begin
            // base address plus 64 bytes per step
            start_address_d = {ADDR_RESET[15:14], req.write_data, 6'd0};
            cur_address_d   = start_address_d;
          end
          REG_LENGTH: begin
            start_length_d = {req.write_data, 4'd1};
            cur_length_d   = start_length_d;
          end
          default: begin
          end
        endcase
      end
      OP_ENABLE: begin
        if (!req.enable) begin
          cur_length_d = 12'd0;
        end else if (cur_length_q == 12'd0) begin
          cur_address_d = start_address_q;
          cur_length_d  = start_length_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_count_q   <= 9'd0;
      timer_period_q  <= 9'd0;
      loop_on_q       <= 1'b0;
      out_level_q     <= 7'd0;
      start_address_q <= ADDR_RESET;
      start_length_q  <= LEN_RESET;
      cur_address_q   <= ADDR_RESET;
      cur_length_q    <= 12'd0;
      sample_byte_q   <= 8'd0;
      sample_valid_q  <= 1'b0;
      shifter_q       <= 8'd0;
      bits_left_q     <= BITS_FULL;
      silent_q        <= 1'b1;
    end else if (fire) begin
      timer_count_q   <= timer_count_d;
      timer_period_q  <= timer_period_d;
      loop_on_q       <= loop_on_d;
      out_level_q     <= out_level_d;
      start_address_q <= start_address_d;
      start_length_q  <= start_length_d;
      cur_address_q   <= cur_address_d;
      cur_length_q    <= cur_length_d;
      sample_byte_q   <= sample_byte_d;
      sample_valid_q  <= sample_valid_d;
      shifter_q       <= shifter_d;
      bits_left_q     <= bits_left_d;
      silent_q        <= silent_d;
    end
  end

  assign rsp_o.level         = out_level_d;
  assign rsp_o.fetched       = fetched;
  assign rsp_o.fetch_address = cur_address_d;
  assign rsp_o.bytes_left    = (cur_length_d != 12'd0);

endmodule

// File: hdl/delta_sample_playback_channel_core.sv
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the output is not stalled; the
// channel state updates in one step between the input and result registers.
// Output stalls back up through the result register to the request ready.
// Reset (asynchronous, active low) empties both registers and puts the
// channel in its idle state: silent, buffer empty, fetch address 0xC000.
// ----------------------------------------------------------------------------
// delta_sample_playback_channel_core
// Delta-modulation sample channel with registered request and result.
// ----------------------------------------------------------------------------
module delta_sample_playback_channel_core import dspc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dspc_req_if.sink          req_i,
  dspc_rsp_if.source        rsp_o
);

`include "delta_sample_playback_channel_core_assert.svh"

  dspc_stage_t stage;
  dspc_rsp_t   rsp_next;
  dspc_rsp_t   rsp_q;
  logic        rsp_valid_q, rsp_valid_d;
  logic        advance;

  // result register is free when empty or being taken
  assign advance = !rsp_valid_q || rsp_o.ready;

  dspc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_req_i   (req_i.payload),
    .in_ready_o (req_i.ready),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  dspc_channel u_channel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_i (advance),
    .rsp_o     (rsp_next)
  );

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (advance) begin
      rsp_valid_d = stage.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage.valid) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  `DSPC_ASSERT_IMP(a_stage_to_result, stage.valid && advance, ##1 rsp_valid_q, "no result")
  `DSPC_ASSERT(a_addr_upper, !rsp_valid_q || rsp_q.fetch_address[15], "address below 0x8000")
  `DSPC_ASSERT_IMP(a_stall_blocks, stage.valid && !advance, !req_i.ready, "request taken when full")

endmodule
